// ===== design/ps2_mouse_packet_cursor_unit_macros.svh =====
// Assertion macros used by the cursor unit's top-level RTL file.
`ifndef PS2_MOUSE_PACKET_CURSOR_UNIT_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PMPC_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PMPC_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PMPC_ASSERT(name, clk, rst_n, prop, msg)
`define PMPC_ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif
`endif

// ===== design/pmpc_pkg.sv =====
// Shared types and constants for the mouse packet cursor unit.
package pmpc_pkg;

    localparam int COORD_WIDTH_DEF     = 12;
    localparam int QUEUE_DEPTH         = 2;
    localparam int SCREEN_WIDTH_RESET  = 800;
    localparam int SCREEN_HEIGHT_RESET = 600;
    localparam int POS_X_RESET         = 400;
    localparam int POS_Y_RESET         = 300;

    localparam logic [7:0] HDR_SYNC   = 8'h08;
    localparam logic [7:0] HDR_LEFT   = 8'h01;
    localparam logic [7:0] HDR_RIGHT  = 8'h02;
    localparam logic [7:0] HDR_MIDDLE = 8'h04;

    typedef enum logic [0:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_X      = 2'd1,
        PH_Y      = 2'd2
    } phase_t;

    typedef struct packed {
        logic       btn_middle;
        logic       btn_right;
        logic       btn_left;
        logic [7:0] x_move;
        logic [7:0] y_move;
    } pkt_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== design/pmpc_front.sv =====
// Byte assembler: tracks packet phase, resyncs on headers, emits whole packets.
module pmpc_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_rx_byte,
    input  pmpc_pkg::q_status_t q_status,
    output logic             pkt_valid,
    output pmpc_pkg::pkt_t   pkt
);
    import pmpc_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [2:0] btn_reg;
    logic [7:0] x_reg;
    logic       accept;
    logic       load_hdr;
    logic       load_x;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            case (phase_reg)
                PH_X:    phase_next = PH_Y;
                PH_Y:    phase_next = PH_HEADER;
                default: phase_next = ((s_rx_byte & HDR_SYNC) != 8'h00) ? PH_X : PH_HEADER;
            endcase
        end
    end

    // outputs per phase
    always_comb begin
        load_hdr  = 1'b0;
        load_x    = 1'b0;
        pkt_valid = 1'b0;
        case (phase_reg)
            PH_X:    load_x    = accept;
            PH_Y:    pkt_valid = accept;
            default: load_hdr  = accept;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_hdr) begin
            btn_reg <= {(s_rx_byte & HDR_MIDDLE) != 8'h00,
                        (s_rx_byte & HDR_RIGHT) != 8'h00,
                        (s_rx_byte & HDR_LEFT) != 8'h00};
        end
        if (load_x) begin
            x_reg <= s_rx_byte;
        end
    end

    always_comb begin
        pkt.btn_middle = btn_reg[2];
        pkt.btn_right  = btn_reg[1];
        pkt.btn_left   = btn_reg[0];
        pkt.x_move     = x_reg;
        pkt.y_move     = s_rx_byte;
    end

endmodule

// ===== design/pmpc_fifo.sv =====
// Short packet queue between the byte assembler and the cursor update.
module pmpc_fifo #(
    parameter int DEPTH = pmpc_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  pmpc_pkg::pkt_t      push_data,
    input  logic                pop,
    output pmpc_pkg::pkt_t      pop_data,
    output pmpc_pkg::q_status_t status
);
    import pmpc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pkt_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/pmpc_back.sv =====
// Cursor update: applies packet movement, clamps to the screen, holds the result register.
module pmpc_back #(
    parameter int COORD_WIDTH = pmpc_pkg::COORD_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pmpc_pkg::q_status_t    q_status,
    input  pmpc_pkg::pkt_t         pkt,
    output logic                   pop,
    input  logic [COORD_WIDTH:0]   width_cfg,
    input  logic [COORD_WIDTH:0]   height_cfg,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COORD_WIDTH-1:0] m_cursor_x,
    output logic [COORD_WIDTH-1:0] m_cursor_y,
    output logic                   m_button_left,
    output logic                   m_button_right,
    output logic                   m_button_middle,
    output logic signed [7:0]      m_delta_x,
    output logic signed [8:0]      m_delta_y
);
    import pmpc_pkg::*;

    localparam int BW = COORD_WIDTH + 1;
    localparam int SW = COORD_WIDTH + 2;

    logic [COORD_WIDTH-1:0] pos_x_reg, pos_x_next;
    logic [COORD_WIDTH-1:0] pos_y_reg, pos_y_next;
    logic                   valid_reg;
    logic signed [8:0]      dy9;
    logic signed [SW-1:0]   sum_x, sum_y;

    // bound register limited to 1..2^COORD_WIDTH
    function automatic logic [BW-1:0] eff_bound(input logic [BW-1:0] r);
        if (r == '0) begin
            eff_bound = BW'(1);
        end else if (r[COORD_WIDTH] && (r[COORD_WIDTH-1:0] != '0)) begin
            eff_bound = {1'b1, {COORD_WIDTH{1'b0}}};
        end else begin
            eff_bound = r;
        end
    endfunction

    function automatic logic [COORD_WIDTH-1:0] clamp(input logic signed [SW-1:0] v,
                                                      input logic [BW-1:0] bound);
        logic signed [SW-1:0] b;
        b = signed'({1'b0, bound});
        if (v[SW-1]) begin
            clamp = '0;
        end else if (v >= b) begin
            clamp = COORD_WIDTH'(bound - BW'(1));
        end else begin
            clamp = v[COORD_WIDTH-1:0];
        end
    endfunction

    assign pop     = !q_status.empty && (!valid_reg || m_ready);
    assign m_valid = valid_reg;

    always_comb begin
        dy9        = -signed'({pkt.y_move[7], pkt.y_move});
        sum_x      = signed'({2'b00, pos_x_reg})
                     + signed'({{(SW-8){pkt.x_move[7]}}, pkt.x_move});
        sum_y      = signed'({2'b00, pos_y_reg}) + signed'({{(SW-9){dy9[8]}}, dy9});
        pos_x_next = clamp(sum_x, eff_bound(width_cfg));
        pos_y_next = clamp(sum_y, eff_bound(height_cfg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_x_reg <= COORD_WIDTH'(POS_X_RESET);
            pos_y_reg <= COORD_WIDTH'(POS_Y_RESET);
        end else begin
            if (pop) begin
                valid_reg <= 1'b1;
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each packet
    always_ff @(posedge aclk) begin
        if (pop) begin
            m_cursor_x      <= pos_x_next;
            m_cursor_y      <= pos_y_next;
            m_button_left   <= pkt.btn_left;
            m_button_right  <= pkt.btn_right;
            m_button_middle <= pkt.btn_middle;
            m_delta_x       <= signed'(pkt.x_move);
            m_delta_y       <= dy9;
        end
    end

endmodule

// ===== design/ps2_mouse_packet_cursor_unit.sv =====
// Top level of the mouse packet decoder with clamped cursor.
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_rx_byte
//  m_      | out       | m_valid / m_ready  | cursor, buttons, deltas
//  cfg_    | in        | cfg_wr_en          | cfg_addr, cfg_wdata
// One byte is taken per cycle while the two-entry packet queue has room.
// A result shows on m_ after the third byte of a packet is taken: the packet first
// enters the queue, then loads the cursor update register once it is free or m_ready is high.
// Reset is synchronous; no clearing pass, the unit takes bytes right after reset.
// A stalled m_ side fills the queue, after which s_ready drops.
module ps2_mouse_packet_cursor_unit #(
    parameter int COORD_WIDTH = pmpc_pkg::COORD_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_rx_byte,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COORD_WIDTH-1:0] m_cursor_x,
    output logic [COORD_WIDTH-1:0] m_cursor_y,
    output logic                   m_button_left,
    output logic                   m_button_right,
    output logic                   m_button_middle,
    output logic signed [7:0]      m_delta_x,
    output logic signed [8:0]      m_delta_y,
    input  logic                   cfg_wr_en,
    input  pmpc_pkg::reg_index_t   cfg_addr,
    input  logic [COORD_WIDTH:0]   cfg_wdata
);
    import pmpc_pkg::*;
    `include "ps2_mouse_packet_cursor_unit_macros.svh"

    logic [COORD_WIDTH:0] width_reg;
    logic [COORD_WIDTH:0] height_reg;
    logic                 pkt_valid;
    pkt_t                 front_pkt;
    pkt_t                 q_pkt;
    q_status_t            q_status;
    logic                 pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= (COORD_WIDTH + 1)'(SCREEN_WIDTH_RESET);
            height_reg <= (COORD_WIDTH + 1)'(SCREEN_HEIGHT_RESET);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_wdata;
                REG_SCREEN_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    pmpc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_status  (q_status),
        .pkt_valid (pkt_valid),
        .pkt       (front_pkt)
    );

    pmpc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (pkt_valid),
        .push_data (front_pkt),
        .pop       (pop),
        .pop_data  (q_pkt),
        .status    (q_status)
    );

    pmpc_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_status        (q_status),
        .pkt             (q_pkt),
        .pop             (pop),
        .width_cfg       (width_reg),
        .height_cfg      (height_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cursor_x      (m_cursor_x),
        .m_cursor_y      (m_cursor_y),
        .m_button_left   (m_button_left),
        .m_button_right  (m_button_right),
        .m_button_middle (m_button_middle),
        .m_delta_x       (m_delta_x),
        .m_delta_y       (m_delta_y)
    );

    `PMPC_ASSERT_NEVER(a_no_push_when_full, aclk, aresetn, pkt_valid && q_status.full, "packet pushed into a full queue")
    `PMPC_ASSERT_NEVER(a_queue_flags, aclk, aresetn, q_status.full && q_status.empty, "queue full and empty at once")
    `PMPC_ASSERT(a_pop_loads_result, aclk, aresetn, pop |=> m_valid, "popped packet did not reach the result register")

endmodule
